// ----- src/sfcs_pkg.sv -----
// Package of the flyback charge sequencer: item types, codes and thresholds.
package sfcs_pkg;

  localparam int unsigned SupplyW  = 14;
  localparam int unsigned VoltsW   = 10;
  localparam int unsigned BudgetW  = 9;
  localparam int unsigned CodeW    = 3;
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  // Register reset values.
  localparam logic [SupplyW-1:0] SupplyMinReset  = 14'd4500;
  localparam logic [SupplyW-1:0] SupplyMaxReset  = 14'd6000;
  localparam logic [BudgetW-1:0] TimeBudgetReset = 9'd450;

  // Stage boundaries of the output voltage, in volts.
  localparam logic [VoltsW-1:0] Stage2Volts = 10'd30;
  localparam logic [VoltsW-1:0] Stage3Volts = 10'd60;
  localparam logic [VoltsW-1:0] Stage4Volts = 10'd150;
  localparam logic [VoltsW-1:0] DoneVolts   = 10'd500;

  // Deadlines of the first three stages on the remaining budget.
  localparam logic [BudgetW-1:0] Stage1Deadline = 9'd430;
  localparam logic [BudgetW-1:0] Stage2Deadline = 9'd380;
  localparam logic [BudgetW-1:0] Stage3Deadline = 9'd300;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } opcode_e;

  typedef enum logic [CodeW-1:0] {
    ST_IDLE     = 3'd0,
    ST_CHARGING = 3'd1,
    ST_DONE     = 3'd2,
    ST_SUPPLY   = 3'd3,
    ST_TIMEOUT  = 3'd4
  } status_e;

  typedef enum logic [CodeW-1:0] {
    BURST_NONE = 3'd0,
    BURST_P1   = 3'd1,
    BURST_P2   = 3'd2,
    BURST_P3   = 3'd3,
    BURST_P4   = 3'd4,
    BURST_P5   = 3'd5
  } burst_e;

  typedef enum logic [CodeW-1:0] {
    STAGE_1    = 3'd1,
    STAGE_2    = 3'd2,
    STAGE_3    = 3'd3,
    STAGE_4    = 3'd4,
    STAGE_DONE = 3'd5
  } stage_e;

  typedef enum logic [7:0] {
    PH_IDLE    = 8'b0000_0001,
    PH_STAGE1  = 8'b0000_0010,
    PH_STAGE2  = 8'b0000_0100,
    PH_STAGE3  = 8'b0000_1000,
    PH_STAGE4  = 8'b0001_0000,
    PH_DONE    = 8'b0010_0000,
    PH_SUPPLY  = 8'b0100_0000,
    PH_TIMEOUT = 8'b1000_0000
  } phase_e;

  typedef enum logic [ApbAddrW-3:0] {
    REG_SUPPLY_MIN  = 2'd0,
    REG_SUPPLY_MAX  = 2'd1,
    REG_TIME_BUDGET = 2'd2
  } reg_idx_e;

  typedef struct packed {
    burst_e  burst;
    status_e status;
  } out_item_t;

endpackage

// ----- src/sfcs_intf.sv -----
// Handshake interfaces of the input and the result channel.
interface sfcs_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [13:0] supply_mv;
  logic [9:0]  target_volts;
  logic [9:0]  out_volts;

  modport source (output valid, output opcode, output supply_mv, output target_volts,
                  output out_volts, input ready);
  modport sink   (input valid, input opcode, input supply_mv, input target_volts,
                  input out_volts, output ready);
endinterface

interface sfcs_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] burst;
  logic [2:0] status;

  modport source (output valid, output burst, output status, input ready);
  modport sink   (input valid, input burst, input status, output ready);
endinterface

// ----- src/staged_flyback_charge_sequencer.sv -----
// Flyback charge sequencer: one result item per accepted input item.
// Latency: the result of an item is valid in the cycle after it is accepted.
// Throughput: one item per cycle; an item is taken whenever the result register
// is empty or is being emptied in the same cycle.
// Reset: registers return to their default values, the run state goes idle with
// zero budget and target, and no result is pending.
module staged_flyback_charge_sequencer
  import sfcs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  sfcs_in_if.sink             in_item,
  sfcs_out_if.source          out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic [SupplyW-1:0] supply_min_q, supply_max_q;
  logic [BudgetW-1:0] time_budget_q;

  phase_e             phase_q, phase_d;
  logic [BudgetW-1:0] budget_q, budget_d;
  logic [VoltsW-1:0]  target_q, target_d;
  status_e            last_status_q, last_status_d;

  out_item_t          out_q, out_d;
  logic               out_valid_q;

  logic               in_acc;
  logic               cfg_wr;
  reg_idx_e           cfg_idx;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[ApbAddrW-1:2]);

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_SUPPLY_MIN:  prdata = ApbDataW'(supply_min_q);
      REG_SUPPLY_MAX:  prdata = ApbDataW'(supply_max_q);
      REG_TIME_BUDGET: prdata = ApbDataW'(time_budget_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      supply_min_q  <= SupplyMinReset;
      supply_max_q  <= SupplyMaxReset;
      time_budget_q <= TimeBudgetReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SUPPLY_MIN:  supply_min_q  <= pwdata[SupplyW-1:0];
        REG_SUPPLY_MAX:  supply_max_q  <= pwdata[SupplyW-1:0];
        REG_TIME_BUDGET: time_budget_q <= pwdata[BudgetW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the result register frees itself when the consumer takes it.
  assign in_item.ready   = !out_valid_q || out_item.ready;
  assign in_acc          = in_item.valid && in_item.ready;
  assign out_item.valid  = out_valid_q;
  assign out_item.burst  = out_q.burst;
  assign out_item.status = out_q.status;

  // Item processing.
  stage_e             samp_stage, held_stage, stage;
  logic               charging, in_window, late, finished;
  logic [BudgetW-1:0] budget_spent;

  always_comb begin
    if (in_item.out_volts < Stage2Volts)      samp_stage = STAGE_1;
    else if (in_item.out_volts < Stage3Volts) samp_stage = STAGE_2;
    else if (in_item.out_volts < Stage4Volts) samp_stage = STAGE_3;
    else if (in_item.out_volts < DoneVolts)   samp_stage = STAGE_4;
    else                                      samp_stage = STAGE_DONE;

    charging = 1'b1;
    case (phase_q)
      PH_STAGE1: held_stage = STAGE_1;
      PH_STAGE2: held_stage = STAGE_2;
      PH_STAGE3: held_stage = STAGE_3;
      PH_STAGE4: held_stage = STAGE_4;
      default: begin
        held_stage = STAGE_1;
        charging   = 1'b0;
      end
    endcase

    // Stages never fall back.
    stage = (samp_stage < held_stage) ? held_stage : samp_stage;

    // The first stage spends its budget before the checks.
    budget_spent = budget_q;
    if (stage == STAGE_1 && budget_q != '0) budget_spent = budget_q - 1'b1;

    finished = (in_item.out_volts > target_q) || (stage == STAGE_DONE);

    case (stage)
      STAGE_1: late = budget_spent < Stage1Deadline;
      STAGE_2: late = budget_spent < Stage2Deadline;
      STAGE_3: late = budget_spent < Stage3Deadline;
      default: late = budget_spent == '0;
    endcase

    in_window = !(in_item.supply_mv < supply_min_q) && !(in_item.supply_mv > supply_max_q);

    phase_d       = phase_q;
    budget_d      = budget_q;
    target_d      = target_q;
    last_status_d = last_status_q;
    out_d.burst   = BURST_NONE;
    out_d.status  = last_status_q;

    if (in_item.opcode == OP_START) begin
      if (in_window) begin
        budget_d      = time_budget_q;
        target_d      = in_item.target_volts;
        phase_d       = PH_STAGE1;
        last_status_d = ST_CHARGING;
        out_d.burst   = BURST_P1;
        out_d.status  = ST_CHARGING;
      end else begin
        phase_d       = PH_SUPPLY;
        last_status_d = ST_SUPPLY;
        out_d.status  = ST_SUPPLY;
      end
    end else if (charging) begin
      budget_d = budget_spent;
      if (finished) begin
        phase_d       = PH_DONE;
        last_status_d = ST_DONE;
        out_d.status  = ST_DONE;
      end else if (late) begin
        phase_d       = PH_TIMEOUT;
        last_status_d = ST_TIMEOUT;
        out_d.status  = ST_TIMEOUT;
      end else begin
        out_d.status = ST_CHARGING;
        out_d.burst  = burst_e'(stage + 3'd1);
        case (stage)
          STAGE_1: phase_d = PH_STAGE1;
          STAGE_2: phase_d = PH_STAGE2;
          STAGE_3: phase_d = PH_STAGE3;
          default: phase_d = PH_STAGE4;
        endcase
        // Later stages spend their budget after issuing the burst.
        if (stage != STAGE_1 && budget_spent != '0) budget_d = budget_spent - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      budget_q      <= '0;
      target_q      <= '0;
      last_status_q <= ST_IDLE;
      out_valid_q   <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q       <= phase_d;
        budget_q      <= budget_d;
        target_q      <= target_d;
        last_status_q <= last_status_d;
        out_valid_q   <= 1'b1;
      end else if (out_item.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) out_q <= out_d;
  end

  // Checks.
  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("run phase lost its one-hot code");

  a_burst_only_charging: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.burst != BURST_NONE |-> out_q.status == ST_CHARGING)
    else $error("burst issued with a non-charging status");

  a_charging_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_STAGE1 || phase_q == PH_STAGE2 || phase_q == PH_STAGE3 ||
     phase_q == PH_STAGE4) |-> last_status_q == ST_CHARGING)
    else $error("charging phase without charging status");

  a_start_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_item.opcode == OP_START && in_window |=>
      out_valid_q && out_q.burst == BURST_P1 && phase_q == PH_STAGE1)
    else $error("accepted start did not open a run");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_item.ready)
    else $error("input stalled while the result register is empty");

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench of the flyback charge sequencer: random and directed items, APB setup.
`timescale 1ns / 1ps
module testbench;
  import sfcs_pkg::*;

  localparam int unsigned QuietLimit = 200;

  typedef struct {
    opcode_e             opcode;
    logic [SupplyW-1:0]  supply_mv;
    logic [VoltsW-1:0]   target_volts;
    logic [VoltsW-1:0]   out_volts;
  } charge_cmd_t;

  // Tracks the charge run as the block should see it and queues the result of each item.
  class charge_scoreboard;
    logic [SupplyW-1:0] supply_min;
    logic [SupplyW-1:0] supply_max;
    logic [BudgetW-1:0] budget_load;
    logic [BudgetW-1:0] budget_left;
    logic [VoltsW-1:0]  target;
    bit                 charging;
    stage_e             stage;
    status_e            last_status;
    out_item_t          pending[$];
    int unsigned        errors, n_items, n_starts, n_runs, n_done, n_supply, n_timeout;

    function new();
      supply_min  = SupplyMinReset;
      supply_max  = SupplyMaxReset;
      budget_load = TimeBudgetReset;
      budget_left = '0;
      target      = '0;
      charging    = 1'b0;
      stage       = STAGE_1;
      last_status = ST_IDLE;
    endfunction

    function void write_reg(reg_idx_e idx, logic [ApbDataW-1:0] value);
      case (idx)
        REG_SUPPLY_MIN:  supply_min = value[SupplyW-1:0];
        REG_SUPPLY_MAX:  supply_max = value[SupplyW-1:0];
        REG_TIME_BUDGET: budget_load = value[BudgetW-1:0];
        default: ;
      endcase
    endfunction

    function stage_e stage_of(logic [VoltsW-1:0] volts);
      if (volts < Stage2Volts) return STAGE_1;
      if (volts < Stage3Volts) return STAGE_2;
      if (volts < Stage4Volts) return STAGE_3;
      if (volts < DoneVolts) return STAGE_4;
      return STAGE_DONE;
    endfunction

    function void note_item(charge_cmd_t cmd);
      out_item_t res;
      stage_e    s;
      bit        late;
      res.burst = BURST_NONE;
      n_items++;
      if (cmd.opcode == OP_START) begin
        n_starts++;
        if (cmd.supply_mv < supply_min || cmd.supply_mv > supply_max) begin
          charging    = 1'b0;
          last_status = ST_SUPPLY;
          res.status  = ST_SUPPLY;
          n_supply++;
        end else begin
          budget_left = budget_load;
          target      = cmd.target_volts;
          stage       = STAGE_1;
          charging    = 1'b1;
          last_status = ST_CHARGING;
          res.burst   = BURST_P1;
          res.status  = ST_CHARGING;
          n_runs++;
        end
      end else if (charging) begin
        // Stages never fall back, even when the sample drops.
        s = stage_of(cmd.out_volts);
        if (s < stage) s = stage;
        if (s == STAGE_1 && budget_left != 0) budget_left--;
        if (cmd.out_volts > target || s == STAGE_DONE) begin
          charging    = 1'b0;
          last_status = ST_DONE;
          res.status  = ST_DONE;
          n_done++;
        end else begin
          case (s)
            STAGE_1: late = budget_left < Stage1Deadline;
            STAGE_2: late = budget_left < Stage2Deadline;
            STAGE_3: late = budget_left < Stage3Deadline;
            default: late = budget_left == 0;
          endcase
          if (late) begin
            charging    = 1'b0;
            last_status = ST_TIMEOUT;
            res.status  = ST_TIMEOUT;
            n_timeout++;
          end else begin
            stage     = s;
            res.burst = burst_e'(s + 3'd1);
            if (s != STAGE_1 && budget_left != 0) budget_left--;
            res.status = ST_CHARGING;
          end
        end
      end else begin
        res.status = last_status;
      end
      pending.push_back(res);
    endfunction

    function void check_result(logic [CodeW-1:0] burst, logic [CodeW-1:0] status);
      out_item_t exp_res;
      if (pending.size() == 0) begin
        $error("result item with no expectation: burst %0d, status %0d", burst, status);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (burst !== exp_res.burst) begin
        $error("burst: expected %0d, got %0d", exp_res.burst, burst);
        errors++;
      end
      if (status !== exp_res.status) begin
        $error("status: expected %0d, got %0d", exp_res.status, status);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  sfcs_in_if  in_bus();
  sfcs_out_if out_bus();

  charge_scoreboard sb;
  bit               idling = 1'b1;
  int unsigned      n_settings = 1;
  int unsigned      quiet_cycles = 0;

  staged_flyback_charge_sequencer dut (
    .clk_i    (clk),
    .rst_ni   (rst_ni),
    .in_item  (in_bus),
    .out_item (out_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #10 clk = ~clk;

  // Ends the run when neither channel nor the register port has moved for too long.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : result_sink
    int unsigned stall;
    out_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk);
    forever begin
      stall = idling ? $urandom_range(0, 7) : 0;
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      sb.check_result(out_bus.burst, out_bus.status);
    end
  end

  // Valid stays high between items when no gap is drawn.
  task automatic send_cmd(charge_cmd_t cmd);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) idling = !idling;
    gap = idling ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      if (in_bus.valid) in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.opcode       <= cmd.opcode;
    in_bus.supply_mv    <= cmd.supply_mv;
    in_bus.target_volts <= cmd.target_volts;
    in_bus.out_volts    <= cmd.out_volts;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_item(cmd);
  endtask

  task automatic send_fields(opcode_e op, int unsigned supply, int unsigned tgt,
                             int unsigned volts);
    charge_cmd_t cmd;
    cmd.opcode       = op;
    cmd.supply_mv    = SupplyW'(supply);
    cmd.target_volts = VoltsW'(tgt);
    cmd.out_volts    = VoltsW'(volts);
    send_cmd(cmd);
  endtask

  task automatic await_results();
    if (in_bus.valid) in_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  task automatic apb_write(reg_idx_e idx, logic [ApbDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.write_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic set_config(int unsigned lo, int unsigned hi, int unsigned load);
    await_results();
    apb_write(REG_SUPPLY_MIN, ApbDataW'(lo));
    apb_write(REG_SUPPLY_MAX, ApbDataW'(hi));
    apb_write(REG_TIME_BUDGET, ApbDataW'(load));
    n_settings++;
  endtask

  task automatic noise_item();
    send_fields(opcode_e'($urandom_range(0, 1)), $urandom_range(0, 16383),
                $urandom_range(0, 1023), $urandom_range(0, 1023));
  endtask

  function automatic int unsigned window_supply();
    if ($urandom_range(0, 9) == 0 || sb.supply_min > sb.supply_max)
      return $urandom_range(0, 16383);
    return $urandom_range(sb.supply_min, sb.supply_max);
  endfunction

  // A start followed by a climbing output voltage, with the odd jump.
  task automatic random_run();
    int unsigned tgt, stride, ticks, volts;
    case ($urandom_range(0, 3))
      0: tgt = $urandom_range(0, 1023);
      1: tgt = $urandom_range(0, 60);
      2: tgt = 1023;
      default: tgt = $urandom_range(100, 600);
    endcase
    send_fields(OP_START, window_supply(), tgt, $urandom_range(0, 1023));
    case ($urandom_range(0, 3))
      0: stride = 1;
      1: stride = 3;
      2: stride = 10;
      default: stride = 40;
    endcase
    ticks = $urandom_range(1, 90);
    volts = 0;
    for (int unsigned i = 0; i < ticks; i++) begin
      if (!sb.charging && $urandom_range(0, 3) != 0) break;
      if ($urandom_range(0, 15) == 0) volts = $urandom_range(0, 1023);
      else volts = volts + $urandom_range(0, stride);
      if (volts > 1023) volts = 1023;
      send_fields(OP_TICK, $urandom_range(0, 16383), $urandom_range(0, 1023), volts);
    end
  endtask

  task automatic random_phase(int unsigned quota);
    int unsigned stop_at;
    stop_at = sb.n_items + quota;
    while (sb.n_items < stop_at) begin
      if ($urandom_range(0, 6) == 0) noise_item();
      else random_run();
    end
  endtask

  initial begin : stimulus
    int unsigned lo;
    sb = new();
    rst_ni              <= 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.opcode       <= OP_START;
    in_bus.supply_mv    <= '0;
    in_bus.target_volts <= '0;
    in_bus.out_volts    <= '0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    repeat (9) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Reset window and budget: faults, every stage, done on target and on the ceiling.
    send_fields(OP_TICK, 5000, 0, 0);
    send_fields(OP_START, 4499, 1023, 0);
    send_fields(OP_TICK, 5000, 0, 10);
    send_fields(OP_START, 16383, 1023, 1023);
    send_fields(OP_START, 0, 0, 0);
    send_fields(OP_START, 4500, 1023, 0);
    send_fields(OP_TICK, 0, 0, 29);
    send_fields(OP_TICK, 0, 0, 30);
    send_fields(OP_TICK, 0, 0, 0);
    send_fields(OP_TICK, 0, 0, 60);
    send_fields(OP_TICK, 0, 0, 150);
    send_fields(OP_TICK, 0, 0, 499);
    send_fields(OP_TICK, 0, 0, 500);
    send_fields(OP_TICK, 16383, 1023, 1023);
    send_fields(OP_START, 6000, 100, 0);
    send_fields(OP_TICK, 0, 0, 101);
    send_fields(OP_START, 6001, 100, 0);
    send_fields(OP_START, 5000, 0, 0);
    send_fields(OP_TICK, 0, 0, 0);
    send_fields(OP_START, 5000, 1023, 0);
    send_fields(OP_TICK, 0, 0, 1023);
    send_fields(OP_START, 4500, 0, 0);
    send_fields(OP_TICK, 0, 0, 1);
    random_phase(220);

    set_config(0, 16383, 511);
    random_phase(120);
    await_results();
    random_phase(120);

    // A zero budget times out at once, in the first stage and in the last.
    set_config(0, 16383, 0);
    send_fields(OP_START, 0, 1023, 0);
    send_fields(OP_TICK, 0, 0, 0);
    send_fields(OP_TICK, 0, 0, 0);
    send_fields(OP_START, 16383, 1023, 0);
    send_fields(OP_TICK, 0, 0, 200);
    random_phase(150);

    // Empty window: every start is a supply fault.
    set_config(16383, 0, 250);
    random_phase(100);

    set_config(5000, 5000, 431);
    random_phase(240);

    lo = $urandom_range(0, 8000);
    set_config(lo, lo + $urandom_range(0, 16383 - lo), 300);
    // Sit in the last stage until its budget runs out.
    send_fields(OP_START, $urandom_range(sb.supply_min, sb.supply_max), 1023, 0);
    while (sb.charging)
      send_fields(OP_TICK, $urandom_range(0, 16383), 0, $urandom_range(150, 499));
    random_phase(220);

    await_results();
    repeat (3) @(posedge clk);
    $display("Sent %0d items under %0d register settings; %0d starts, %0d of them began a run.",
             sb.n_items, n_settings, sb.n_starts, sb.n_runs);
    $display("Outcomes: %0d done, %0d supply faults, %0d timeouts; %0d mismatches.",
             sb.n_done, sb.n_supply, sb.n_timeout, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
